[sv/bslp_pkg.sv]
`default_nettype none

package bslp_pkg;

  localparam int BUTTONS   = 5;
  localparam int TIME_BITS = 32;
  localparam int FIELD_W   = 5;
  localparam int QUERY_W   = 3;
  localparam int LONG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 1'd1;

  localparam logic [LONG_W-1:0]  HOLD_LIMIT_RST  = 16'd1000;
  localparam logic [FIELD_W-1:0] ENABLE_MASK_RST = 5'd31;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [31:0]         now_ms;
    logic [FIELD_W-1:0]  pin_levels;
    logic [FIELD_W-1:0]  consume_short_mask;
    logic [FIELD_W-1:0]  consume_long_mask;
    logic [QUERY_W-1:0]  query_button;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  short_pending;
    logic [FIELD_W-1:0]  long_pending;
    logic [FIELD_W-1:0]  down_mask;
    logic [31:0]         held_ms;
  } out_t;

endpackage

`default_nettype wire

[sv/button_short_long_press.sv]
// Short / long press classifier for five active-low buttons.
//
// Input channel (in_valid / in_ready / in_data): one item per sample, carrying
// a millisecond timestamp, raw pin levels, flag consume masks and the index
// of the button whose held time is wanted.
// Output channel (out_valid / out_ready / out_data): one result item per
// input item, in order: pending short and long flags, enabled down mask and
// held time of the queried button.
// Configuration: cfg_write with cfg_index selects hold_limit (0) or
// enable_mask (1); write only while no item is in flight.
//
// An accepted item passes through the input register, then the result
// register, before out_valid rises. Throughput: one item per cycle while the
// receiver does not stall; the per-button update (a subtract and a compare
// per button) sits between those two registers.
// Reset clears all button state, flags and both stages, and restores
// hold_limit to 1000 and enable_mask to all ones. When the receiver
// stalls, the result register holds, the input register fills behind it and
// in_ready falls; nothing is dropped.
`default_nettype none

module button_short_long_press (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire bslp_pkg::in_t                     in_data,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      bslp_pkg::out_t                    out_data,
  input  wire logic                              cfg_write,
  input  wire logic [bslp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bslp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int B = bslp_pkg::BUTTONS;

  logic [bslp_pkg::LONG_W-1:0]  hold_limit;
  logic [bslp_pkg::FIELD_W-1:0] enable_mask;

  logic          s1_valid;
  bslp_pkg::in_t s1_data;
  logic          s1_move;
  logic          out_free;

  logic [B-1:0]          was_down;
  bslp_pkg::time_t       press_time [B];
  logic [B-1:0]          long_done;
  logic [B-1:0]          short_flag;
  logic [B-1:0]          long_flag;

  logic [B-1:0]          was_down_next;
  bslp_pkg::time_t       press_time_next [B];
  logic [B-1:0]          long_done_next;
  logic [B-1:0]          short_set;
  logic [B-1:0]          long_set;
  bslp_pkg::time_t       dt [B];
  logic [B-1:0]          down;
  logic [B-1:0]          en;

  bslp_pkg::time_t       now_t;
  bslp_pkg::time_t       long_t;
  bslp_pkg::time_t       held;
  bslp_pkg::out_t        out_data_next;

  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  assign in_ready = !s1_valid || s1_move;

  assign now_t  = bslp_pkg::time_t'(s1_data.now_ms);
  assign long_t = bslp_pkg::time_t'(hold_limit);

  always_comb begin
    for (int i = 0; i < B; i++) begin
      en[i]   = (i < bslp_pkg::FIELD_W) ? enable_mask[i] : 1'b0;
      down[i] = (i < bslp_pkg::FIELD_W) ? !s1_data.pin_levels[i] : 1'b0;
      was_down_next[i]   = was_down[i];
      press_time_next[i] = press_time[i];
      long_done_next[i]  = long_done[i];
      short_set[i]       = 1'b0;
      long_set[i]        = 1'b0;
      dt[i]              = '0;
      if (en[i]) begin
        if (down[i] && !was_down[i]) begin
          press_time_next[i] = now_t;
          long_done_next[i]  = 1'b0;
        end
        dt[i] = now_t - press_time_next[i];
        if (!down[i] && was_down[i] && !long_done_next[i] && (dt[i] < long_t)) begin
          short_set[i] = 1'b1;
        end
        if (down[i] && !long_done_next[i] && (dt[i] >= long_t)) begin
          long_set[i]       = 1'b1;
          long_done_next[i] = 1'b1;
        end
        was_down_next[i] = down[i];
      end
    end
  end

  always_comb begin
    held = '0;
    if ((32'(s1_data.query_button) < 32'(B)) && was_down_next[s1_data.query_button]) begin
      held = now_t - press_time_next[s1_data.query_button];
    end
  end

  always_comb begin
    out_data_next = '0;
    for (int i = 0; i < B && i < bslp_pkg::FIELD_W; i++) begin
      out_data_next.short_pending[i] = short_flag[i] | short_set[i];
      out_data_next.long_pending[i]  = long_flag[i] | long_set[i];
      out_data_next.down_mask[i]     = was_down_next[i] & en[i];
    end
    out_data_next.held_ms = 32'(held);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit  <= bslp_pkg::HOLD_LIMIT_RST;
      enable_mask <= bslp_pkg::ENABLE_MASK_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bslp_pkg::CFG_HOLD_LIMIT:  hold_limit  <= cfg_data[bslp_pkg::LONG_W-1:0];
        bslp_pkg::CFG_ENABLE_MASK: enable_mask <= cfg_data[bslp_pkg::FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= out_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_down   <= '0;
      long_done  <= '0;
      short_flag <= '0;
      long_flag  <= '0;
      for (int i = 0; i < B; i++) begin
        press_time[i] <= '0;
      end
    end else if (s1_move) begin
      was_down  <= was_down_next;
      long_done <= long_done_next;
      for (int i = 0; i < B; i++) begin
        press_time[i] <= press_time_next[i];
        short_flag[i] <= (short_flag[i] | short_set[i]) &
                         !((i < bslp_pkg::FIELD_W) ? s1_data.consume_short_mask[i] : 1'b0);
        long_flag[i]  <= (long_flag[i] | long_set[i]) &
                         !((i < bslp_pkg::FIELD_W) ? s1_data.consume_long_mask[i] : 1'b0);
      end
    end
  end

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("input stage lost an item during stall");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("empty input stage not ready");

  a_down_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.down_mask & ~enable_mask) == '0))
    else $error("disabled button reported down");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !s1_valid))
    else $error("stages not cleared by reset");

endmodule

`default_nettype wire
